// File: rtl/core/motion_watch_tracking_controller_assert.svh
// Assertion helpers for the motion watch controller.
// Both forms sample on i_clk and are held off while i_rst_n is low.
`ifndef MOTION_WATCH_TRACKING_CONTROLLER_ASSERT_SVH
`define MOTION_WATCH_TRACKING_CONTROLLER_ASSERT_SVH

// cond must hold at every rising edge of i_clk.
`define MWTC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// cons must hold in the cycle after ante.
`define MWTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/mwtc_pkg.sv
`default_nettype none

package mwtc_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_MOTION_HOLD = 3'd0;
    localparam logic [2:0] CFG_SCAN_LIMIT  = 3'd1;
    localparam logic [2:0] CFG_CONFIRM     = 3'd2;
    localparam logic [2:0] CFG_COOLDOWN    = 3'd3;
    localparam logic [2:0] CFG_EXIT_HOLD   = 3'd4;
    localparam logic [2:0] CFG_ENTRY_CM    = 3'd5;
    localparam logic [2:0] CFG_EXIT_CM     = 3'd6;
    localparam logic [2:0] CFG_SWEEP_STEP  = 3'd7;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 20;

    // Config reset values
    localparam logic [15:0] RST_MOTION_HOLD = 16'd500;
    localparam logic [19:0] RST_SCAN_LIMIT  = 20'd20000;
    localparam logic [15:0] RST_CONFIRM     = 16'd3000;
    localparam logic [15:0] RST_COOLDOWN    = 16'd3000;
    localparam logic [15:0] RST_EXIT_HOLD   = 16'd2000;
    localparam logic [9:0]  RST_ENTRY_CM    = 10'd100;
    localparam logic [9:0]  RST_EXIT_CM     = 10'd120;
    localparam logic [7:0]  RST_SWEEP_STEP  = 8'd20;

    // Distance: echo*343/20000. The divide is a shift by 5 followed by
    // a reciprocal multiply for /625 (exact for a 19-bit dividend).
    localparam int unsigned ECHO_W      = 15;
    localparam int unsigned DIST_W      = 10;
    localparam logic [8:0]  ECHO_MUL    = 9'd343;
    localparam int unsigned PROD_W      = 24;
    localparam int unsigned PRE_SHIFT   = 5;
    localparam int unsigned QUOT_IN_W   = PROD_W - PRE_SHIFT;
    localparam logic [19:0] RECIP_625   = 20'd858994;
    localparam int unsigned RECIP_SHIFT = 29;
    localparam int unsigned RECIP_PW    = QUOT_IN_W + 20;
    localparam logic [9:0]  RANGE_RESET = 10'd400;

    // Angles and timing constants
    localparam logic [7:0]  HEAD_RESET  = 8'd90;
    localparam logic [7:0]  HELD_RESET  = 8'd90;
    localparam logic [7:0]  TAIL_RESET  = 8'd120;
    localparam logic [7:0]  TAIL_IDLE   = 8'd40;
    localparam logic [7:0]  TAIL_SCAN   = 8'd130;
    localparam logic [7:0]  TAIL_COOL   = 8'd120;
    localparam logic [7:0]  SWEEP_MAX   = 8'd180;
    localparam logic [7:0]  WOB_LO      = 8'd40;
    localparam logic [7:0]  WOB_HI      = 8'd110;
    localparam logic [7:0]  WOB_STEP    = 8'd5;
    localparam logic [31:0] WOBBLE_MS   = 32'd30;
    localparam logic [31:0] BEEP_MS     = 32'd300;

    // Watch modes, one-hot
    typedef enum logic [4:0] {
        MODE_IDLE = 5'b00001,
        MODE_SCAN = 5'b00010,
        MODE_CONF = 5'b00100,
        MODE_LOCK = 5'b01000,
        MODE_COOL = 5'b10000
    } t_mode;

    localparam logic [2:0] CODE_IDLE = 3'd0;
    localparam logic [2:0] CODE_SCAN = 3'd1;
    localparam logic [2:0] CODE_CONF = 3'd2;
    localparam logic [2:0] CODE_LOCK = 3'd3;
    localparam logic [2:0] CODE_COOL = 3'd4;

    function automatic logic [2:0] mode_code(input t_mode m);
        logic [2:0] c;
        unique case (m)
            MODE_IDLE: c = CODE_IDLE;
            MODE_SCAN: c = CODE_SCAN;
            MODE_CONF: c = CODE_CONF;
            MODE_LOCK: c = CODE_LOCK;
            MODE_COOL: c = CODE_COOL;
            default:   c = CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/motion_watch_tracking_controller.sv
// Pipeline: an input item passes the multiply stage, the reciprocal-divide stage, then the
//   watch-machine update into the result register, from which its result is presented.
// Throughput: one item per cycle while m_axis_tready does not stall the output; the watch
//   state is read and written in the last stage only.
// Reset: i_rst_n is synchronous, active low; it empties the pipeline, sets the watch state
//   to idle with its documented start values and reloads all config registers to defaults.
`default_nettype none

module motion_watch_tracking_controller
    import mwtc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input items
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [31:0] time_ms, [32] motion, [47:33] echo_us
    input  wire logic [47:0]           s_axis_tdata,
    // result items
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [2:0] mode, [10:3] head_angle, [18:11] tail_deg, [26:19] lock_angle,
    // [27] stand, [28] buzzer_on, [38:29] distance_cm, [39] zero
    output logic [39:0]                m_axis_tdata,
    // config writes
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    logic [15:0] r_motion_hold;
    logic [19:0] r_scan_limit;
    logic [15:0] r_confirm;
    logic [15:0] r_cooldown;
    logic [15:0] r_exit_hold;
    logic [9:0]  r_entry_cm;
    logic [9:0]  r_exit_cm;
    logic [7:0]  r_sweep_step;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motion_hold <= RST_MOTION_HOLD;
            r_scan_limit  <= RST_SCAN_LIMIT;
            r_confirm     <= RST_CONFIRM;
            r_cooldown    <= RST_COOLDOWN;
            r_exit_hold   <= RST_EXIT_HOLD;
            r_entry_cm    <= RST_ENTRY_CM;
            r_exit_cm     <= RST_EXIT_CM;
            r_sweep_step  <= RST_SWEEP_STEP;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MOTION_HOLD: r_motion_hold <= i_cfg_data[15:0];
                CFG_SCAN_LIMIT:  r_scan_limit  <= i_cfg_data[19:0];
                CFG_CONFIRM:     r_confirm     <= i_cfg_data[15:0];
                CFG_COOLDOWN:    r_cooldown    <= i_cfg_data[15:0];
                CFG_EXIT_HOLD:   r_exit_hold   <= i_cfg_data[15:0];
                CFG_ENTRY_CM:    r_entry_cm    <= i_cfg_data[9:0];
                CFG_EXIT_CM:     r_exit_cm     <= i_cfg_data[9:0];
                CFG_SWEEP_STEP:  r_sweep_step  <= i_cfg_data[7:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake. Each stage moves when the one after it is empty
    // or moving, so bubbles close up while the output is stalled.
    // ------------------------------------------------------------------
    logic r_a_valid, r_b_valid, r_c_valid;
    logic c_free, b_free, a_free, upd;

    assign c_free        = !r_c_valid || m_axis_tready;
    assign b_free        = !r_b_valid || c_free;
    assign a_free        = !r_a_valid || b_free;
    assign upd           = r_b_valid && c_free;   // item enters the watch machine
    assign s_axis_tready = a_free;
    assign m_axis_tvalid = r_c_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (a_free) r_a_valid <= s_axis_tvalid;
            if (b_free) r_b_valid <= r_a_valid;
            if (c_free) r_c_valid <= r_b_valid;
        end
    end

    // Stage A: echo * 343
    logic [31:0]       r_a_time;
    logic              r_a_motion;
    logic              r_a_echo_nz;
    logic [PROD_W-1:0] r_a_prod;

    always_ff @(posedge i_clk) begin
        if (a_free && s_axis_tvalid) begin
            r_a_time    <= s_axis_tdata[31:0];
            r_a_motion  <= s_axis_tdata[32];
            r_a_echo_nz <= (s_axis_tdata[47:33] != '0);
            r_a_prod    <= PROD_W'(s_axis_tdata[47:33]) * PROD_W'(ECHO_MUL);
        end
    end

    // Stage B: divide by 20000 = (prod >> 5) * ceil(2^29/625) >> 29
    logic [RECIP_PW-1:0] recip_prod;
    logic [31:0]         r_b_time;
    logic                r_b_motion;
    logic                r_b_echo_nz;
    logic [DIST_W-1:0]   r_b_dist;

    assign recip_prod = RECIP_PW'(r_a_prod[PROD_W-1:PRE_SHIFT]) * RECIP_PW'(RECIP_625);

    always_ff @(posedge i_clk) begin
        if (b_free && r_a_valid) begin
            r_b_time    <= r_a_time;
            r_b_motion  <= r_a_motion;
            r_b_echo_nz <= r_a_echo_nz;
            r_b_dist    <= recip_prod[RECIP_SHIFT +: DIST_W];
        end
    end

    // ------------------------------------------------------------------
    // Watch machine state
    // ------------------------------------------------------------------
    t_mode       r_mode,          n_mode;
    logic [31:0] r_motion_since,  n_motion_since;
    logic [31:0] r_scan_since,    n_scan_since;
    logic [31:0] r_confirm_since, n_confirm_since;
    logic [31:0] r_cool_since,    n_cool_since;
    logic [31:0] r_leave_since,   n_leave_since;
    logic [31:0] r_last_sweep,    n_last_sweep;
    logic [31:0] r_last_wobble,   n_last_wobble;
    logic [31:0] r_last_beep,     n_last_beep;
    logic [7:0]  r_sweep_pos,     n_sweep_pos;
    logic        r_sweep_down,    n_sweep_down;
    logic [7:0]  r_held_angle,    n_held_angle;
    logic [7:0]  r_wobble_pos,    n_wobble_pos;
    logic        r_wobble_down,   n_wobble_down;
    logic [7:0]  r_head_cmd,      n_head_cmd;
    logic [7:0]  r_tail_cmd,      n_tail_cmd;
    logic        r_standing,      n_standing;
    logic        r_beep,          n_beep;
    logic [9:0]  r_range,         n_range;

    // Per-pass helper values
    logic [31:0] t;
    logic [31:0] motion_mark, leave_mark;
    logic [7:0]  sweep_step_pos, wobble_step_pos;
    logic        wobble_due;

    assign t       = r_b_time;
    assign n_range = r_b_echo_nz ? r_b_dist : r_range;   // zero echo keeps last distance

    // zero timestamp doubles as "timer not started"
    assign motion_mark = (r_motion_since == '0) ? t : r_motion_since;
    assign leave_mark  = (r_leave_since == '0) ? t : r_leave_since;

    assign sweep_step_pos  = r_sweep_down ? (r_sweep_pos - 8'd1) : (r_sweep_pos + 8'd1);
    assign wobble_step_pos = r_wobble_down ? (r_wobble_pos - WOB_STEP)
                                           : (r_wobble_pos + WOB_STEP);
    assign wobble_due      = (t - r_last_wobble) >= WOBBLE_MS;

    always_comb begin
        n_mode          = r_mode;
        n_motion_since  = r_motion_since;
        n_scan_since    = r_scan_since;
        n_confirm_since = r_confirm_since;
        n_cool_since    = r_cool_since;
        n_leave_since   = r_leave_since;
        n_last_sweep    = r_last_sweep;
        n_last_wobble   = r_last_wobble;
        n_last_beep     = r_last_beep;
        n_sweep_pos     = r_sweep_pos;
        n_sweep_down    = r_sweep_down;
        n_held_angle    = r_held_angle;
        n_wobble_pos    = r_wobble_pos;
        n_wobble_down   = r_wobble_down;
        n_head_cmd      = r_head_cmd;
        n_tail_cmd      = r_tail_cmd;
        n_standing      = r_standing;
        n_beep          = r_beep;

        unique case (r_mode)
            MODE_IDLE: begin
                n_tail_cmd = TAIL_IDLE;
                if (r_b_motion) begin
                    n_motion_since = motion_mark;
                    if ((t - motion_mark) >= 32'(r_motion_hold)) begin
                        n_mode         = MODE_SCAN;
                        n_scan_since   = t;
                        n_motion_since = '0;
                    end
                end else begin
                    n_motion_since = '0;
                end
            end
            MODE_SCAN: begin
                n_tail_cmd = TAIL_SCAN;
                if ((t - r_last_sweep) > 32'(r_sweep_step)) begin
                    n_last_sweep = t;
                    n_sweep_pos  = sweep_step_pos;
                    n_head_cmd   = sweep_step_pos;
                    if (sweep_step_pos >= SWEEP_MAX || sweep_step_pos == '0)
                        n_sweep_down = !r_sweep_down;
                end
                // capture the angle reached in this same pass
                if (n_range < r_entry_cm) begin
                    n_held_angle    = n_sweep_pos;
                    n_confirm_since = t;
                    n_mode          = MODE_CONF;
                    n_wobble_pos    = WOB_LO;
                    n_wobble_down   = 1'b0;
                end
                // timeout overrides a target seen in the same pass
                if ((t - r_scan_since) >= 32'(r_scan_limit)) begin
                    n_mode       = MODE_COOL;
                    n_cool_since = t;
                end
            end
            MODE_CONF: begin
                if (wobble_due) begin
                    n_last_wobble = t;
                    n_wobble_pos  = wobble_step_pos;
                    n_tail_cmd    = wobble_step_pos;
                    if (wobble_step_pos > WOB_HI || wobble_step_pos < WOB_LO)
                        n_wobble_down = !r_wobble_down;
                end
                n_head_cmd = r_held_angle;
                // falls back to scanning with the scan timer still running
                if (n_range > r_entry_cm)
                    n_mode = MODE_SCAN;
                else if ((t - r_confirm_since) >= 32'(r_confirm))
                    n_mode = MODE_LOCK;
            end
            MODE_LOCK: begin
                n_standing = 1'b1;
                if (wobble_due) begin
                    n_last_wobble = t;
                    n_wobble_pos  = wobble_step_pos;
                    n_tail_cmd    = wobble_step_pos;
                    if (wobble_step_pos > WOB_HI || wobble_step_pos < WOB_LO)
                        n_wobble_down = !r_wobble_down;
                end
                n_head_cmd = r_held_angle;
                if (n_range > r_exit_cm) begin
                    n_leave_since = leave_mark;
                    if ((t - leave_mark) >= 32'(r_exit_hold)) begin
                        n_mode        = MODE_SCAN;
                        n_scan_since  = t;
                        n_leave_since = '0;
                    end
                end else begin
                    n_leave_since = '0;
                end
            end
            MODE_COOL: begin
                n_tail_cmd = TAIL_COOL;
                n_standing = 1'b0;
                if ((t - r_cool_since) >= 32'(r_cooldown))
                    n_mode = MODE_IDLE;
            end
            default: begin
            end
        endcase

        // buzzer toggles only while locked after this pass
        if (n_mode == MODE_LOCK) begin
            if ((t - r_last_beep) >= BEEP_MS) begin
                n_last_beep = t;
                n_beep      = !r_beep;
            end
        end else begin
            n_beep = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= MODE_IDLE;
            r_motion_since  <= '0;
            r_scan_since    <= '0;
            r_confirm_since <= '0;
            r_cool_since    <= '0;
            r_leave_since   <= '0;
            r_last_sweep    <= '0;
            r_last_wobble   <= '0;
            r_last_beep     <= '0;
            r_sweep_pos     <= '0;
            r_sweep_down    <= 1'b0;
            r_held_angle    <= HELD_RESET;
            r_wobble_pos    <= WOB_LO;
            r_wobble_down   <= 1'b0;
            r_head_cmd      <= HEAD_RESET;
            r_tail_cmd      <= TAIL_RESET;
            r_standing      <= 1'b0;
            r_beep          <= 1'b0;
            r_range         <= RANGE_RESET;
        end else if (upd) begin
            r_mode          <= n_mode;
            r_motion_since  <= n_motion_since;
            r_scan_since    <= n_scan_since;
            r_confirm_since <= n_confirm_since;
            r_cool_since    <= n_cool_since;
            r_leave_since   <= n_leave_since;
            r_last_sweep    <= n_last_sweep;
            r_last_wobble   <= n_last_wobble;
            r_last_beep     <= n_last_beep;
            r_sweep_pos     <= n_sweep_pos;
            r_sweep_down    <= n_sweep_down;
            r_held_angle    <= n_held_angle;
            r_wobble_pos    <= n_wobble_pos;
            r_wobble_down   <= n_wobble_down;
            r_head_cmd      <= n_head_cmd;
            r_tail_cmd      <= n_tail_cmd;
            r_standing      <= n_standing;
            r_beep          <= n_beep;
            r_range         <= n_range;
        end
    end

    // Result register
    logic [39:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (upd) begin
            r_out_data <= {1'b0, n_range, n_beep, n_standing, n_held_angle,
                           n_tail_cmd, n_head_cmd, mode_code(n_mode)};
        end
    end

    assign m_axis_tdata = r_out_data;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `include "motion_watch_tracking_controller_assert.svh"

    `MWTC_ASSERT_ALWAYS(a_beep_only_locked, !r_beep || r_mode == MODE_LOCK, "buzzer on outside lock")
    `MWTC_ASSERT_NEXT(a_mode_holds_idle, !upd, $stable(r_mode), "mode moved without an item")
    `MWTC_ASSERT_NEXT(a_idle_exit, upd && r_mode == MODE_IDLE, r_mode == MODE_IDLE || r_mode == MODE_SCAN, "idle left to a mode other than scanning")
    `MWTC_ASSERT_ALWAYS(a_sweep_range, r_sweep_pos <= SWEEP_MAX && r_held_angle <= SWEEP_MAX, "head angle out of range")
    `MWTC_ASSERT_NEXT(a_result_follows, upd, m_axis_tvalid, "result register not loaded")

endmodule

`default_nettype wire

// File: verif/motion_watch_checker.sv
`timescale 1ns / 1ps

module motion_watch_checker
    import mwtc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [47:0]           s_axis_tdata,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [39:0]           m_axis_tdata,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_mismatch_count,
    output int                    o_results_due
);

    // Laid out MSB first, so it maps straight onto m_axis_tdata.
    typedef struct packed {
        logic       pad;
        logic [9:0] distance;
        logic       buzzer;
        logic       stand;
        logic [7:0] lock;
        logic [7:0] tail;
        logic [7:0] head;
        logic [2:0] mode;
    } t_watch_result;

    // Settings
    logic [15:0] hold_motion_ms;
    logic [19:0] limit_scan_ms;
    logic [15:0] need_confirm_ms;
    logic [15:0] need_cool_ms;
    logic [15:0] need_exit_ms;
    logic [9:0]  near_cm;
    logic [9:0]  far_cm;
    logic [7:0]  sweep_tick_ms;

    // Watch state
    logic [2:0]  w_mode;
    logic [31:0] t_motion, t_scan, t_confirm, t_cool;
    logic [31:0] t_leave, t_sweep, t_wobble, t_beep;
    int          head_pos;
    bit          head_down;
    logic [7:0]  lock_pos;
    int          tail_pos;
    bit          tail_down;
    logic [7:0]  head_out;
    logic [7:0]  tail_out;
    bit          standing;
    bit          beep;
    logic [9:0]  dist_cm;

    t_watch_result results_due[$];
    int            mismatch_count = 0;

    task automatic nudge_tail(input logic [31:0] t_ms);
        if ((t_ms - t_wobble) >= WOBBLE_MS) begin
            t_wobble = t_ms;
            tail_pos += tail_down ? -int'(WOB_STEP) : int'(WOB_STEP);
            if (tail_pos > int'(WOB_HI) || tail_pos < int'(WOB_LO))
                tail_down = !tail_down;
            tail_out = tail_pos[7:0];
        end
    endtask

    task automatic advance_watch(input logic [31:0] t_ms, input logic moving,
                                 input logic [14:0] echo_us, output t_watch_result r);
        logic [31:0] scaled;
        scaled = {17'd0, echo_us} * 32'd343;
        if (echo_us != '0)
            dist_cm = 10'(scaled / 32'd20000);

        case (w_mode)
            CODE_IDLE: begin
                tail_out = TAIL_IDLE;
                if (moving) begin
                    if (t_motion == '0)
                        t_motion = t_ms;
                    if ((t_ms - t_motion) >= hold_motion_ms) begin
                        w_mode   = CODE_SCAN;
                        t_scan   = t_ms;
                        t_motion = '0;
                    end
                end else begin
                    t_motion = '0;
                end
            end
            CODE_SCAN: begin
                tail_out = TAIL_SCAN;
                if ((t_ms - t_sweep) > sweep_tick_ms) begin
                    t_sweep = t_ms;
                    head_pos += head_down ? -1 : 1;
                    if (head_pos >= int'(SWEEP_MAX) || head_pos <= 0)
                        head_down = !head_down;
                    head_out = head_pos[7:0];
                end
                if (dist_cm < near_cm) begin
                    lock_pos  = head_pos[7:0];
                    t_confirm = t_ms;
                    w_mode    = CODE_CONF;
                    tail_pos  = int'(WOB_LO);
                    tail_down = 1'b0;
                end
                // timeout beats a target seen in the same pass
                if ((t_ms - t_scan) >= limit_scan_ms) begin
                    w_mode = CODE_COOL;
                    t_cool = t_ms;
                end
            end
            CODE_CONF: begin
                nudge_tail(t_ms);
                head_out = lock_pos;
                if (dist_cm > near_cm)
                    w_mode = CODE_SCAN;   // scan timer keeps running
                else if ((t_ms - t_confirm) >= need_confirm_ms)
                    w_mode = CODE_LOCK;
            end
            CODE_LOCK: begin
                standing = 1'b1;
                nudge_tail(t_ms);
                head_out = lock_pos;
                if (dist_cm > far_cm) begin
                    if (t_leave == '0)
                        t_leave = t_ms;
                    if ((t_ms - t_leave) >= need_exit_ms) begin
                        w_mode  = CODE_SCAN;
                        t_scan  = t_ms;
                        t_leave = '0;
                    end
                end else begin
                    t_leave = '0;
                end
            end
            CODE_COOL: begin
                tail_out = TAIL_COOL;
                standing = 1'b0;
                if ((t_ms - t_cool) >= need_cool_ms)
                    w_mode = CODE_IDLE;
            end
            default: ;
        endcase

        if (w_mode == CODE_LOCK) begin
            if ((t_ms - t_beep) >= BEEP_MS) begin
                t_beep = t_ms;
                beep   = !beep;
            end
        end else begin
            beep = 1'b0;
        end

        r.pad      = 1'b0;
        r.mode     = w_mode;
        r.head     = head_out;
        r.tail     = tail_out;
        r.lock     = lock_pos;
        r.stand    = standing;
        r.buzzer   = beep;
        r.distance = dist_cm;
    endtask

    task automatic flag_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch on %s: expected %0d, got %0d", field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch_check
        t_watch_result got;
        t_watch_result want;
        if (!i_rst_n) begin
            hold_motion_ms  = RST_MOTION_HOLD;
            limit_scan_ms   = RST_SCAN_LIMIT;
            need_confirm_ms = RST_CONFIRM;
            need_cool_ms    = RST_COOLDOWN;
            need_exit_ms    = RST_EXIT_HOLD;
            near_cm         = RST_ENTRY_CM;
            far_cm          = RST_EXIT_CM;
            sweep_tick_ms   = RST_SWEEP_STEP;
            w_mode    = CODE_IDLE;
            t_motion  = '0;
            t_scan    = '0;
            t_confirm = '0;
            t_cool    = '0;
            t_leave   = '0;
            t_sweep   = '0;
            t_wobble  = '0;
            t_beep    = '0;
            head_pos  = 0;
            head_down = 1'b0;
            lock_pos  = HELD_RESET;
            tail_pos  = int'(WOB_LO);
            tail_down = 1'b0;
            head_out  = HEAD_RESET;
            tail_out  = TAIL_RESET;
            standing  = 1'b0;
            beep      = 1'b0;
            dist_cm   = RANGE_RESET;
            results_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MOTION_HOLD: hold_motion_ms  = i_cfg_data[15:0];
                    CFG_SCAN_LIMIT:  limit_scan_ms   = i_cfg_data[19:0];
                    CFG_CONFIRM:     need_confirm_ms = i_cfg_data[15:0];
                    CFG_COOLDOWN:    need_cool_ms    = i_cfg_data[15:0];
                    CFG_EXIT_HOLD:   need_exit_ms    = i_cfg_data[15:0];
                    CFG_ENTRY_CM:    near_cm         = i_cfg_data[9:0];
                    CFG_EXIT_CM:     far_cm          = i_cfg_data[9:0];
                    CFG_SWEEP_STEP:  sweep_tick_ms   = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            // Compare before predicting: a result never belongs to the item
            // accepted at the same edge.
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (results_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result item with none expected: %h", m_axis_tdata);
                end else begin
                    want = results_due.pop_front();
                    flag_field("mode", want.mode, got.mode);
                    flag_field("head_angle", want.head, got.head);
                    flag_field("tail_deg", want.tail, got.tail);
                    flag_field("lock_angle", want.lock, got.lock);
                    flag_field("stand", want.stand, got.stand);
                    flag_field("buzzer_on", want.buzzer, got.buzzer);
                    flag_field("distance_cm", want.distance, got.distance);
                    flag_field("pad bit", want.pad, got.pad);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                advance_watch(s_axis_tdata[31:0], s_axis_tdata[32], s_axis_tdata[47:33], want);
                results_due.push_back(want);
            end
        end
        o_results_due    <= results_due.size();
        o_mismatch_count <= mismatch_count;
    end

endmodule

// File: verif/tb_motion_watch_tracking_controller.sv
`timescale 1ns / 1ps

module tb_motion_watch_tracking_controller
    import mwtc_pkg::*;
();

    // Three pipeline stages from input item to result item.
    localparam int          LATENCY     = 3;
    // Watchdog bound on the whole run, which includes gaps, stalls and config writes.
    localparam logic [31:0] CYCLE_LIMIT = 32'd400000;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [31:0] time_ms, [32] motion, [47:33] echo_us
    logic [47:0]           s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [2:0] mode, [10:3] head, [18:11] tail, [26:19] lock, [27] stand,
    // [28] buzzer_on, [38:29] distance_cm, [39] zero
    logic [39:0]           m_axis_tdata;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    int          mismatch_count;
    int          results_due;
    logic [31:0] cycle_count = '0;

    // Stimulus state: the virtual clock of the robot and the scene it sees.
    logic [31:0] now_ms      = '0;
    bit          near_target = 1'b0;
    bit          moving      = 1'b0;
    int          burst_left  = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    motion_watch_tracking_controller i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    motion_watch_checker i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_mismatch_count (mismatch_count),
        .o_results_due    (results_due)
    );

    // Cycle counter, watchdog and receiver back-pressure. The stall pattern
    // is picked by cycle_count[10:9]: always ready, mostly ready, mostly
    // stalled, then a fixed periodic pattern.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        case (cycle_count[10:9])
            2'd0:    m_axis_tready <= 1'b1;
            2'd1:    m_axis_tready <= ($urandom_range(0, 3) != 0);
            2'd2:    m_axis_tready <= ($urandom_range(0, 2) == 0);
            default: m_axis_tready <= (cycle_count[2:0] != 3'd5) && (cycle_count[4:3] != 2'd2);
        endcase
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // One control pass. The sender runs in bursts of random length; between
    // bursts tvalid drops for a random gap (sometimes none at all). tvalid is
    // left high after acceptance so a burst streams back to back.
    task automatic send_item(input logic [31:0] t_ms, input logic motion,
                             input logic [14:0] echo_us);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {echo_us, motion, t_ms};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Drop tvalid, wait for every outstanding result, then let the pipeline settle.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (results_due != 0);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic apply_settings(input logic [19:0] hold, input logic [19:0] scan,
                                  input logic [19:0] conf, input logic [19:0] cool,
                                  input logic [19:0] exit_hold, input logic [19:0] entry,
                                  input logic [19:0] leave, input logic [19:0] sweep);
        write_reg(CFG_MOTION_HOLD, hold);
        write_reg(CFG_SCAN_LIMIT, scan);
        write_reg(CFG_CONFIRM, conf);
        write_reg(CFG_COOLDOWN, cool);
        write_reg(CFG_EXIT_HOLD, exit_hold);
        write_reg(CFG_ENTRY_CM, entry);
        write_reg(CFG_EXIT_CM, leave);
        write_reg(CFG_SWEEP_STEP, sweep);
        i_cfg_valid <= 1'b0;
    endtask

    // Random scene: time moves forward in small steps, with the odd long jump
    // or random absolute timestamp as noise. Motion and target presence flip
    // now and then so the watch machine walks through all its modes.
    task automatic roam(input int n_items, input int step_max, input int jump_max);
        int          pick;
        logic        motion;
        logic [14:0] echo_us;
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 39) == 0)
                near_target = !near_target;
            if ($urandom_range(0, 29) == 0)
                moving = !moving;
            pick = $urandom_range(0, 99);
            if (pick < 2)
                now_ms = $urandom();
            else if (pick < 5)
                now_ms += $urandom_range(0, jump_max);
            else
                now_ms += $urandom_range(0, step_max);
            motion = moving ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 9) == 0);
            pick = $urandom_range(0, 9);
            if (pick == 0)
                echo_us = '0;                             // no echo, keep last range
            else if (pick == 1)
                echo_us = 15'($urandom_range(0, 30000));
            else if (near_target)
                echo_us = 15'($urandom_range(1, 5500));   // 0..94 cm
            else
                echo_us = 15'($urandom_range(7500, 30000)); // 128..514 cm
            send_item(now_ms, motion, echo_us);
        end
    endtask

    initial begin
        logic [9:0] entry;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: motion starting at timestamp zero keeps the mark
        // unset, field extremes, a cooldown timed across the 32-bit wrap.
        send_item(32'd0, 1'b1, 15'd0);
        send_item(32'd0, 1'b1, 15'd30000);
        send_item(32'd1, 1'b1, 15'd1);
        send_item(32'd600, 1'b1, 15'd16384);
        send_item(32'hFFFF_FFFF, 1'b0, 15'd0);
        send_item(32'h5555_5555, 1'b1, 15'h2AAA);
        send_item(32'hAAAA_AAAA, 1'b0, 15'h5555);
        wait_idle();

        // Short timers: walk idle, scan, confirm, lock, leave, then a target
        // seen in the pass where the scan runs out (cooldown wins).
        apply_settings(20'd10, 20'd1000, 20'd50, 20'd100, 20'd40, 20'd100, 20'd120, 20'd0);
        send_item(32'd1000, 1'b1, 15'd0);
        send_item(32'd1010, 1'b1, 15'd0);
        send_item(32'd1020, 1'b0, 15'd20000);
        send_item(32'd1030, 1'b0, 15'd3000);
        send_item(32'd1060, 1'b0, 15'd0);
        send_item(32'd1070, 1'b0, 15'd6000);      // drifts out: back to scanning
        send_item(32'd1075, 1'b0, 15'd3000);
        send_item(32'd1090, 1'b0, 15'd0);
        send_item(32'd1130, 1'b0, 15'd0);
        send_item(32'd1160, 1'b0, 15'd30000);
        send_item(32'd1210, 1'b0, 15'd30000);
        send_item(32'd1211, 1'b0, 15'd30000);
        send_item(32'd3000, 1'b0, 15'd1000);
        send_item(32'd3050, 1'b0, 15'd0);
        send_item(32'd3100, 1'b1, 15'd0);
        wait_idle();

        // Fast timers, typical distances.
        apply_settings(20'd50, 20'd2500, 20'd300, 20'd400, 20'd200, 20'd100, 20'd120, 20'd3);
        now_ms = 32'd100;
        roam(550, 40, 5000);
        wait_idle();

        // Every register at zero.
        apply_settings(20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0);
        roam(150, 30, 2000);
        wait_idle();

        // Every register at its maximum; large time steps to make progress.
        apply_settings(20'hFFFF, 20'hFFFFF, 20'hFFFF, 20'hFFFF, 20'hFFFF,
                       20'h3FF, 20'h3FF, 20'hFF);
        roam(200, 3000, 200000);

        // Random settings, with junk above the width of every register narrower than 20 bits.
        repeat (3) begin
            wait_idle();
            entry = 10'($urandom_range(40, 250));
            apply_settings({4'($urandom), 16'($urandom_range(0, 300))},
                           20'($urandom_range(0, 4000)),
                           {4'($urandom), 16'($urandom_range(0, 500))},
                           {4'($urandom), 16'($urandom_range(0, 600))},
                           {4'($urandom), 16'($urandom_range(0, 300))},
                           {10'($urandom), entry},
                           {10'($urandom), 10'(entry + $urandom_range(0, 60))},
                           {12'($urandom), 8'($urandom)});
            now_ms = $urandom();
            roam(250, 50, 3000);
        end
        wait_idle();

        // Back to the reset values, crossing the timestamp wrap.
        apply_settings(20'(RST_MOTION_HOLD), RST_SCAN_LIMIT, 20'(RST_CONFIRM),
                       20'(RST_COOLDOWN), 20'(RST_EXIT_HOLD), 20'(RST_ENTRY_CM),
                       20'(RST_EXIT_CM), 20'(RST_SWEEP_STEP));
        now_ms = 32'hFFFF_0000;
        roam(250, 200, 30000);
        wait_idle();

        if (mismatch_count == 0 && results_due == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/mwtc_pkg.sv
rtl/core/motion_watch_tracking_controller.sv
verif/motion_watch_checker.sv
verif/tb_motion_watch_tracking_controller.sv
